// File: hdl/ght_pkg.sv
// shared types and constants of the generational handle table
`default_nettype none

package ght_pkg;

	// table geometry and field widths
	localparam int ENTRIES = 256;
	localparam int IDX_W   = 8;
	localparam int CNT_W   = 9;
	localparam int KEY_W   = 16;
	localparam int DATA_W  = 32;

	// request opcodes
	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_GET   = 2'd2,
		CMD_FIND  = 2'd3
	} ght_cmd_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_END  = 2'd3
	} ght_status_t;

	// request beat
	typedef struct packed {
		logic [1:0]        command;
		logic [IDX_W-1:0]  handle_index;
		logic [KEY_W-1:0]  handle_key;
		logic [DATA_W-1:0] payload;
	} req_beat_t;

	// response beat
	typedef struct packed {
		logic [CNT_W-1:0]  out_index;
		logic [KEY_W-1:0]  out_key;
		logic [DATA_W-1:0] out_payload;
		logic [1:0]        status;
		logic [CNT_W-1:0]  live_count;
	} rsp_beat_t;

	// one slot memory word
	typedef struct packed {
		logic              is_free;
		logic [KEY_W-1:0]  key;
		logic [IDX_W-1:0]  next_free;
		logic [DATA_W-1:0] payload;
	} slot_t;

	// controller states
	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} ght_fsm_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic step;
		logic finish;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_step;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/ght_ctrl.sv
// controller state machine of the generational handle table
`default_nettype none

module ght_ctrl
	import ght_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  wire      req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  wire      rsp_stall,
	output ctl_cmd_t cmd,
	input  dp_stat_t stat
);

	ght_fsm_t state_q;
	ght_fsm_t state_d;
	logic     rsp_valid_q;

	// state and response valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			FSM_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (stat.scan_step) begin
					cmd.step = 1'b1;
				end else if (!rsp_valid_q || !rsp_stall) begin
					cmd.finish = 1'b1;
					state_d    = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

// File: hdl/ght_dpath.sv
// slot memory, table counters and response register of the handle table
`default_nettype none

module ght_dpath
	import ght_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  req_beat_t req,
	input  ctl_cmd_t  cmd,
	output dp_stat_t  stat,
	output rsp_beat_t rsp
);

	slot_t            mem [ENTRIES];
	slot_t            rd_q;
	ght_cmd_t         cmd_q;
	logic [CNT_W-1:0] ptr_q;
	logic [KEY_W-1:0] key_q;
	logic [DATA_W-1:0] data_q;
	logic [CNT_W-1:0] created_q;
	logic [CNT_W-1:0] head_q;
	logic [CNT_W-1:0] total_q;
	rsp_beat_t        rsp_q;

	logic [CNT_W-1:0] ptr_inc;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;
	logic             in_range;
	logic             live;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	slot_t            wr_data;
	logic [CNT_W-1:0] head_d;
	logic [CNT_W-1:0] created_d;
	logic [CNT_W-1:0] total_d;
	rsp_beat_t        res;

	// read address: free list head for alloc, handle index otherwise, next slot when scanning
	assign ptr_inc = ptr_q + 1'b1;
	assign rd_en   = cmd.accept | cmd.step;
	always_comb begin
		if (cmd.accept) begin
			if (ght_cmd_t'(req.command) == CMD_ALLOC) begin
				rd_addr = head_q[IDX_W-1:0];
			end else begin
				rd_addr = req.handle_index;
			end
		end else begin
			rd_addr = ptr_inc[IDX_W-1:0];
		end
	end

	// handle check and scan progress
	assign in_range       = ptr_q < created_q;
	assign live           = in_range && !rd_q.is_free && (rd_q.key == key_q);
	assign stat.scan_step = (cmd_q == CMD_FIND) && in_range && rd_q.is_free;

	// command execution on the slot that was read
	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = ptr_q[IDX_W-1:0];
		wr_data    = rd_q;
		head_d     = head_q;
		created_d  = created_q;
		total_d    = total_q;
		res        = '0;
		res.status = ST_OK;
		case (cmd_q)
			CMD_ALLOC: begin
				if (head_q < CNT_W'(ENTRIES) && head_q < created_q) begin
					// reuse the free list head
					wr_en           = 1'b1;
					wr_addr         = head_q[IDX_W-1:0];
					wr_data.is_free = 1'b0;
					wr_data.payload = data_q;
					if (rd_q.next_free == head_q[IDX_W-1:0]) begin
						head_d = CNT_W'(ENTRIES);
					end else begin
						head_d = CNT_W'(rd_q.next_free);
					end
					total_d       = total_q + 1'b1;
					res.out_index = head_q;
					res.out_key   = rd_q.key;
				end else if (created_q >= CNT_W'(ENTRIES)) begin
					res.status = ST_FULL;
				end else begin
					// append a fresh slot with key zero
					wr_en             = 1'b1;
					wr_addr           = created_q[IDX_W-1:0];
					wr_data.is_free   = 1'b0;
					wr_data.key       = '0;
					wr_data.next_free = '0;
					wr_data.payload   = data_q;
					created_d         = created_q + 1'b1;
					total_d           = total_q + 1'b1;
					res.out_index     = created_q;
				end
			end
			CMD_FREE: begin
				if (live) begin
					wr_en           = 1'b1;
					wr_data.is_free = 1'b1;
					wr_data.key     = KEY_W'(rd_q.key + 1'b1);
					if (head_q < CNT_W'(ENTRIES)) begin
						wr_data.next_free = head_q[IDX_W-1:0];
					end else begin
						wr_data.next_free = ptr_q[IDX_W-1:0];
					end
					head_d = ptr_q;
					if (total_q != '0) begin
						total_d = total_q - 1'b1;
					end
					res.out_index = ptr_q;
					res.out_key   = KEY_W'(rd_q.key + 1'b1);
				end else begin
					res.status = ST_MISS;
				end
			end
			CMD_GET: begin
				if (live) begin
					res.out_index   = ptr_q;
					res.out_key     = rd_q.key;
					res.out_payload = rd_q.payload;
				end else begin
					res.status = ST_MISS;
				end
			end
			default: begin
				// find next used slot
				if (!in_range) begin
					res.out_index = created_q;
					res.status    = ST_END;
				end else begin
					res.out_index = ptr_q;
					res.out_key   = rd_q.key;
				end
			end
		endcase
		res.live_count = total_d;
	end

	// slot memory with registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (wr_en && cmd.finish) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// request capture, scan pointer and response register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q  <= ght_cmd_t'(req.command);
			ptr_q  <= CNT_W'(req.handle_index);
			key_q  <= req.handle_key;
			data_q <= req.payload;
		end else if (cmd.step) begin
			ptr_q <= ptr_inc;
		end
		if (cmd.finish) begin
			rsp_q <= res;
		end
	end

	// table counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			created_q <= '0;
			head_q    <= CNT_W'(ENTRIES);
			total_q   <= '0;
		end else if (cmd.finish) begin
			created_q <= created_d;
			head_q    <= head_d;
			total_q   <= total_d;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// File: hdl/generational_handle_table_top.sv
// top level of the generational handle table
//
// Request channel (req_valid, req_stall, req) carries one command beat:
// alloc, free, get or find next used slot. Response channel (rsp_valid,
// rsp_stall, rsp) returns exactly one beat per request, in order.
// A request beat is taken whenever the controller is idle. The slot
// memory has one registered read port, so alloc, free and get read
// the slot when the beat is taken and check and write it back in the
// execute state. Find next used slot reads one slot per cycle from the
// start index, skipping free slots (at most 256). The response sits in
// an output register; the next request is accepted while it waits, and
// a stalled receiver only holds the following command in its final
// cycle until the register drains. Reset clears the slot count, live
// count and free list head; slot contents need no clearing since only
// created slots are ever used.
`default_nettype none

module generational_handle_table_top
	import ght_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  wire       rsp_stall,
	output rsp_beat_t rsp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	ght_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	ght_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// File: tb/ght_checker.sv
// response checker for the generational handle table: predicts every response and compares
`default_nettype none

module ght_checker
	import ght_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       req_valid,
	input  wire       req_stall,
	input  req_beat_t req,
	input  wire       rsp_valid,
	input  wire       rsp_stall,
	input  rsp_beat_t rsp,
	output int        errors,
	output int        outstanding
);

	// predicted table contents
	logic [DATA_W-1:0] slot_data [ENTRIES];
	logic [IDX_W-1:0]  slot_link [ENTRIES];
	logic [KEY_W-1:0]  slot_key  [ENTRIES];
	bit                slot_free [ENTRIES];
	int unsigned       n_created = 0;
	int unsigned       free_head = ENTRIES;
	int unsigned       n_live = 0;

	// responses still owed by the table, oldest first
	rsp_beat_t         owed_rsp [$];
	rsp_beat_t         want_rsp;

	initial errors = 0;

	task automatic report_error(input string msg);
		if (errors < 100)
			$display("error at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic bit handle_live(int unsigned idx, logic [KEY_W-1:0] key);
		return idx < n_created && !slot_free[idx] && slot_key[idx] == key;
	endfunction

	// apply one command to the predicted table and build its response
	function automatic rsp_beat_t table_step(req_beat_t b);
		rsp_beat_t   r;
		int unsigned s;
		int unsigned idx;
		r = '0;
		idx = b.handle_index;
		case (b.command)
			CMD_ALLOC: begin
				if (free_head < n_created) begin
					// reuse the free list head; a self link marks the list end
					s = free_head;
					free_head = (slot_link[s] == IDX_W'(s)) ? ENTRIES : slot_link[s];
					slot_free[s] = 1'b0;
					slot_data[s] = b.payload;
					n_live++;
					r.out_index = CNT_W'(s);
					r.out_key = slot_key[s];
				end else if (n_created >= ENTRIES) begin
					r.status = ST_FULL;
				end else begin
					// append a fresh slot with key zero
					s = n_created;
					n_created++;
					slot_data[s] = b.payload;
					slot_key[s] = '0;
					slot_free[s] = 1'b0;
					slot_link[s] = '0;
					n_live++;
					r.out_index = CNT_W'(s);
				end
			end
			CMD_FREE: begin
				if (!handle_live(idx, b.handle_key)) begin
					r.status = ST_MISS;
				end else begin
					slot_key[idx] = slot_key[idx] + 1'b1;
					slot_free[idx] = 1'b1;
					slot_link[idx] = (free_head < ENTRIES) ? IDX_W'(free_head) : IDX_W'(idx);
					free_head = idx;
					if (n_live > 0)
						n_live--;
					r.out_index = CNT_W'(idx);
					r.out_key = slot_key[idx];
				end
			end
			CMD_GET: begin
				if (!handle_live(idx, b.handle_key)) begin
					r.status = ST_MISS;
				end else begin
					r.out_index = CNT_W'(idx);
					r.out_key = slot_key[idx];
					r.out_payload = slot_data[idx];
				end
			end
			default: begin
				// scan upward for the first used slot
				r.status = ST_END;
				r.out_index = CNT_W'(n_created);
				for (s = idx; s < n_created && r.status == ST_END; s++) begin
					if (!slot_free[s]) begin
						r.status = ST_OK;
						r.out_index = CNT_W'(s);
						r.out_key = slot_key[s];
					end
				end
			end
		endcase
		r.live_count = CNT_W'(n_live);
		return r;
	endfunction

	// predict on request beats, compare on response beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_created = 0;
			free_head = ENTRIES;
			n_live = 0;
			owed_rsp.delete();
			outstanding = 0;
		end else begin
			if (req_valid && !req_stall)
				owed_rsp.insert(owed_rsp.size(), table_step(req));
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsp.size() == 0) begin
					report_error("response beat with no request waiting");
				end else begin
					want_rsp = owed_rsp.pop_front();
					if (rsp.out_index !== want_rsp.out_index)
						report_error($sformatf("out_index %0d, expected %0d",
							rsp.out_index, want_rsp.out_index));
					if (rsp.out_key !== want_rsp.out_key)
						report_error($sformatf("out_key %0h, expected %0h",
							rsp.out_key, want_rsp.out_key));
					if (rsp.out_payload !== want_rsp.out_payload)
						report_error($sformatf("out_payload %0h, expected %0h",
							rsp.out_payload, want_rsp.out_payload));
					if (rsp.status !== want_rsp.status)
						report_error($sformatf("status %0d, expected %0d",
							rsp.status, want_rsp.status));
					if (rsp.live_count !== want_rsp.live_count)
						report_error($sformatf("live_count %0d, expected %0d",
							rsp.live_count, want_rsp.live_count));
				end
			end
			outstanding = owed_rsp.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/tb.sv
// testbench top for the generational handle table: clock, reset, stimulus and verdict
`default_nettype none

module tb;
	import ght_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_beat_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp;
	bit        quiet = 1'b0;
	int        errors;
	int        outstanding;

	generational_handle_table_top uut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	ght_checker chk (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp,
		.errors,
		.outstanding
	);

	always #6 clk = ~clk;

	// random back-pressure on the response side
	always @(negedge clk)
		rsp_stall <= !quiet && ($urandom_range(0, 99) < 7);

	// hard stop on a hung run
	initial begin
		#96000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic req_beat_t mk_beat(ght_cmd_t c, int unsigned idx, int unsigned key,
			logic [DATA_W-1:0] data);
		req_beat_t b;
		b.command = c;
		b.handle_index = IDX_W'(idx);
		b.handle_key = KEY_W'(key);
		b.payload = data;
		return b;
	endfunction

	// drive one request beat and hold it until taken
	task automatic send_beat(input req_beat_t b);
		if (!quiet && $urandom_range(0, 99) < 7) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req <= b;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// find some used slot, starting at a random place
	function automatic bit pick_live(output int unsigned idx);
		int unsigned start;
		int unsigned s;
		idx = 0;
		if (chk.n_created == 0)
			return 1'b0;
		start = $urandom_range(0, chk.n_created - 1);
		for (int unsigned j = 0; j < chk.n_created; j++) begin
			s = (start + j) % chk.n_created;
			if (!chk.slot_free[s]) begin
				idx = s;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// random command, mostly valid handles, with a mix tilted by phase
	task automatic random_beat(input int phase, output req_beat_t b);
		int unsigned r;
		int unsigned h;
		int unsigned idx;
		int unsigned alloc_pct;
		int unsigned free_pct;
		b = mk_beat(CMD_GET, $urandom_range(0, 255), $urandom_range(0, 65535), $urandom());
		case (phase)
			0: begin alloc_pct = 60; free_pct = 15; end
			1: begin alloc_pct = 35; free_pct = 30; end
			2: begin alloc_pct = 90; free_pct = 3; end
			3: begin alloc_pct = 10; free_pct = 70; end
			4: begin alloc_pct = 40; free_pct = 35; end
			default: begin alloc_pct = 45; free_pct = 25; end
		endcase
		r = $urandom_range(0, 99);
		if (r < alloc_pct)
			b.command = CMD_ALLOC;
		else if (r < alloc_pct + free_pct)
			b.command = CMD_FREE;
		else if (r < 90)
			b.command = CMD_GET;
		else
			b.command = CMD_FIND;
		h = $urandom_range(0, 99);
		if (b.command == CMD_FIND) begin
			if (h < 50)
				b.handle_index = IDX_W'($urandom_range(0, chk.n_created));
		end else if (b.command != CMD_ALLOC && h < 85 && pick_live(idx)) begin
			b.handle_index = IDX_W'(idx);
			b.handle_key = chk.slot_key[idx];
			// stale handle: the generation just before the current one
			if (h >= 75)
				b.handle_key = chk.slot_key[idx] - 1'b1;
		end else if (b.command != CMD_ALLOC && h < 90 && chk.n_created > 0) begin
			// current key of any created slot, free or not
			idx = $urandom_range(0, chk.n_created - 1);
			b.handle_index = IDX_W'(idx);
			b.handle_key = chk.slot_key[idx];
		end
	endtask

	initial begin
		req_beat_t   b;
		int unsigned k;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// empty table, first slots, stale and double frees, free list order
		send_beat(mk_beat(CMD_FIND, 0, 0, 0));
		send_beat(mk_beat(CMD_GET, 0, 0, 0));
		send_beat(mk_beat(CMD_FREE, 255, 16'hffff, 0));
		send_beat(mk_beat(CMD_ALLOC, 0, 0, '0));
		send_beat(mk_beat(CMD_ALLOC, 255, 16'hffff, '1));
		send_beat(mk_beat(CMD_ALLOC, 0, 0, 32'ha5a5_5a5a));
		send_beat(mk_beat(CMD_GET, 0, 0, '1));
		send_beat(mk_beat(CMD_GET, 1, 0, 0));
		send_beat(mk_beat(CMD_GET, 1, 1, 0));
		send_beat(mk_beat(CMD_FREE, 1, 0, 0));
		send_beat(mk_beat(CMD_FREE, 1, 0, 0));
		send_beat(mk_beat(CMD_FREE, 1, 1, 0));
		send_beat(mk_beat(CMD_GET, 1, 0, 0));
		send_beat(mk_beat(CMD_FIND, 1, 0, 0));
		send_beat(mk_beat(CMD_FIND, 3, 0, 0));
		send_beat(mk_beat(CMD_FREE, 0, 0, 0));
		send_beat(mk_beat(CMD_FIND, 0, 0, 0));
		send_beat(mk_beat(CMD_ALLOC, 0, 0, 32'h1234_5678));
		send_beat(mk_beat(CMD_ALLOC, 0, 0, 32'h8765_4321));
		send_beat(mk_beat(CMD_ALLOC, 0, 0, 32'hdead_beef));
		send_beat(mk_beat(CMD_FIND, 255, 0, 0));
		send_beat(mk_beat(CMD_GET, 255, 0, 0));

		// recycle slot 3 a few times so its generation key keeps moving
		send_beat(mk_beat(CMD_FREE, 3, chk.slot_key[3], 0));
		for (k = 0; k < 8; k++) begin
			send_beat(mk_beat(CMD_ALLOC, 0, 0, $urandom()));
			send_beat(mk_beat(CMD_FREE, 3, chk.slot_key[3], 0));
		end
		send_beat(mk_beat(CMD_ALLOC, 0, 0, $urandom()));

		// random traffic: grow, churn, fill, drain, churn, mixed
		for (int i = 0; i < 1800; i++) begin
			quiet <= (i >= 900 && i < 1200);
			if (i == 600) begin
				// let every response come back before going on
				req_valid <= 1'b0;
				do @(negedge clk); while (outstanding != 0);
			end
			random_beat(i / 300, b);
			send_beat(b);
		end
		req_valid <= 1'b0;

		// drain and decide
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
hdl/ght_pkg.sv
hdl/ght_ctrl.sv
hdl/ght_dpath.sv
hdl/generational_handle_table_top.sv
tb/ght_checker.sv
tb/tb.sv
